### rtl/ffa_pkg.sv
package ffa_pkg;
  localparam int MaxBlocks   = 64;
  localparam int HeaderBytes = 24;
  localparam int OffBits     = 16;
  localparam int IdxBits     = $clog2(MaxBlocks);
  localparam int CntBits     = $clog2(MaxBlocks + 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CHECK, ST_SHIFT_RD, ST_SHIFT_WR, ST_WRITE, ST_DONE
  } ffa_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the transaction
    logic clr_idx;   // idx = 0
    logic inc_idx;
    logic dec_idx;
    logic set_scan;  // idx = shift start (alloc: count, free: pos)
    logic rd;        // issue table read at rd_addr
    logic rd_prev;   // read idx-1 (alloc shift)
    logic rd_next;   // read idx+1 (free shift)
    logic shift_wr;  // write shifted entry at idx
    logic ins_wr;    // write new entry at idx
    logic take;      // record hit at idx
    logic cnt_inc;
    logic cnt_dec;
    logic set_res;
  } ffa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic full;
    logic at_end;    // idx == count
    logic hit;       // current gap fits / header matches
    logic last_free; // idx+1 >= count during free shift
    logic at_pos;    // idx == pos during alloc shift
  } ffa_sts_t;
endpackage

### rtl/ffa_datapath.sv
module ffa_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ffa_pkg::ffa_cmd_t              cmd_i,
  output ffa_pkg::ffa_sts_t              sts_o,
  input  logic                           cfg_we,
  input  logic [15:0]                    cfg_wdata,
  input  logic                           in_cmd,
  input  logic [15:0]                    in_request_size,
  input  logic [15:0]                    in_target_offset,
  output logic                           res_status,
  output logic [15:0]                    res_offset
);
  import ffa_pkg::*;

  logic [OffBits-1:0] start_mem [MaxBlocks];
  logic [OffBits-1:0] end_mem   [MaxBlocks];
  logic [OffBits-1:0] rd_start_r, rd_end_r;
  logic [15:0]        arena_r;
  logic [CntBits-1:0] count_r, idx_r, pos_r;
  logic               op_r, found_r;
  logic [16:0]        need_r;
  logic [15:0]        target_r;
  logic [OffBits-1:0] at_r;
  logic [OffBits-1:0] lo, hi;
  logic [CntBits-1:0] rd_addr, idx_m1, idx_p1;
  logic               fits, match;

  assign idx_m1 = idx_r - CntBits'(1);
  assign idx_p1 = idx_r + CntBits'(1);

  always_comb begin
    if (cmd_i.rd_prev) rd_addr = idx_m1;
    else if (cmd_i.rd_next) rd_addr = idx_p1;
    else rd_addr = idx_r;
  end

  // gap bounds: lo from previous entry end, hi from current start or arena
  logic [OffBits-1:0] prev_end_r;
  assign lo = (idx_r == '0) ? '0 : prev_end_r;
  assign hi = (idx_r == count_r) ? OffBits'(arena_r) : rd_start_r;
  assign fits  = (hi >= lo) && ({1'b0, hi - lo} >= need_r);
  assign match = (idx_r != count_r) &&
                 ({1'b0, rd_start_r} + 17'(HeaderBytes) == {1'b0, target_r});

  assign sts_o.is_free   = op_r;
  assign sts_o.full      = (count_r == CntBits'(MaxBlocks));
  assign sts_o.at_end    = (idx_r == count_r);
  assign sts_o.hit       = (op_r == CMD_FREE) ? match : fits;
  assign sts_o.last_free = (idx_p1 >= count_r);
  assign sts_o.at_pos    = (idx_r == pos_r);

  always_ff @(posedge clk) begin
    if (cmd_i.rd) begin
      rd_start_r <= start_mem[rd_addr[IdxBits-1:0]];
      rd_end_r   <= end_mem[rd_addr[IdxBits-1:0]];
    end
    if (cmd_i.shift_wr) begin
      start_mem[idx_r[IdxBits-1:0]] <= rd_start_r;
      end_mem[idx_r[IdxBits-1:0]]   <= rd_end_r;
    end
    if (cmd_i.ins_wr) begin
      start_mem[idx_r[IdxBits-1:0]] <= at_r;
      end_mem[idx_r[IdxBits-1:0]]   <= OffBits'(17'(at_r) + need_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r <= 16'd4096;
      count_r <= '0;
    end else begin
      if (cfg_we) arena_r <= cfg_wdata;
      if (cmd_i.cnt_inc) count_r <= count_r + CntBits'(1);
      if (cmd_i.cnt_dec) count_r <= count_r - CntBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r     <= in_cmd;
      need_r   <= 17'(in_request_size) + 17'(HeaderBytes);
      target_r <= in_target_offset;
      found_r  <= 1'b0;
    end
    if (cmd_i.clr_idx) begin
      idx_r <= '0;
    end else if (cmd_i.set_scan) begin
      idx_r <= (op_r == CMD_FREE) ? pos_r : count_r;
    end else if (cmd_i.inc_idx) begin
      idx_r      <= idx_p1;
      prev_end_r <= rd_end_r;
    end else if (cmd_i.dec_idx) begin
      idx_r <= idx_m1;
    end
    if (cmd_i.take) begin
      pos_r   <= idx_r;
      at_r    <= lo;
      found_r <= 1'b1;
    end
    if (cmd_i.set_res) begin
      res_status <= !found_r;
      if (op_r == CMD_FREE) res_offset <= '0;
      else if (found_r) res_offset <= 16'(17'(at_r) + 17'(HeaderBytes));
      else res_offset <= arena_r;
    end
  end
endmodule

### rtl/ffa_ctrl.sv
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ffa_pkg::ffa_sts_t sts_i,
  output ffa_pkg::ffa_cmd_t cmd_o,
  output logic              busy,
  output logic              done
);
  import ffa_pkg::*;

  ffa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    busy      = (state_r != ST_IDLE);
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load    = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        if (!sts_i.is_free && sts_i.full) begin
          state_nxt = ST_DONE;
        end else begin
          cmd_o.rd  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.hit) begin
          cmd_o.take     = 1'b1;
          state_nxt      = ST_WRITE;
        end else if (sts_i.at_end) begin
          state_nxt = ST_DONE;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_WRITE: begin
        // position idx at the shift start
        cmd_o.set_scan = 1'b1;
        state_nxt      = ST_SHIFT_RD;
      end
      ST_SHIFT_RD: begin
        if (sts_i.is_free) begin
          if (sts_i.last_free) begin
            cmd_o.cnt_dec = 1'b1;
            state_nxt     = ST_DONE;
          end else begin
            cmd_o.rd      = 1'b1;
            cmd_o.rd_next = 1'b1;
            state_nxt     = ST_SHIFT_WR;
          end
        end else if (sts_i.at_pos) begin
          cmd_o.ins_wr  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          cmd_o.rd      = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_nxt     = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        if (sts_i.is_free) begin
          // the delayed strobe stores entry idx+1 at idx and advances idx
          state_nxt = ST_SHIFT_RD;
        end else begin
          cmd_o.shift_wr = 1'b1;
          cmd_o.dec_idx  = 1'b1;
          state_nxt      = ST_SHIFT_RD;
        end
      end
      ST_DONE: begin
        cmd_o.set_res = 1'b1;
        done          = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### rtl/ffa_free_wr.sv
module ffa_free_wr (
  input  logic clk,
  input  logic rst_n,
  input  logic arm,
  output logic pend
);
  // delayed write strobe for the free shift: write in the cycle after the read
  logic pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else        pend_r <= arm;
  end
  assign pend = pend_r;
endmodule

### rtl/first_fit_arena_allocator.sv
// First-fit allocator over a 64-entry address-ordered block table. An
// allocate walks the gaps one table entry at a time, reading then checking
// each, then shifts the tail up one entry at a time (read, then write) to
// insert; a free scans for the header and shifts the tail down the same way.
// A result is held in an output register and the next transaction is taken
// once it is read, so no new transaction is taken while one is still being
// worked on or its result is waiting to be read.
module first_fit_arena_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_target_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [15:0] out_result_offset
);
  import ffa_pkg::*;

  ffa_cmd_t cmd, cmd_dp;
  ffa_sts_t sts;
  logic     busy, done, start, pend, out_valid_r;

  assign in_stall = busy || (out_valid_r && out_stall);
  assign start    = in_valid && !in_stall;

  ffa_ctrl u_ctrl (
    .clk, .rst_n, .start, .sts_i(sts), .cmd_o(cmd), .busy, .done
  );

  // free shift writes the entry read last cycle at idx, then advances idx
  ffa_free_wr u_fwr (
    .clk, .rst_n, .arm(cmd.rd_next), .pend
  );

  always_comb begin
    cmd_dp = cmd;
    if (pend) begin
      cmd_dp.shift_wr = 1'b1;
      cmd_dp.inc_idx  = 1'b1;
    end
  end

  ffa_datapath u_dp (
    .clk, .rst_n, .cmd_i(cmd_dp), .sts_o(sts), .cfg_we, .cfg_wdata,
    .in_cmd, .in_request_size, .in_target_offset,
    .res_status(out_status), .res_offset(out_result_offset)
  );

  always_ff @(posedge clk) begin
    if (!rst_n)                      out_valid_r <= 1'b0;
    else if (done)                   out_valid_r <= 1'b1;
    else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
  end
  assign out_valid = out_valid_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !start) else $error("start while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid) else $error("result lost");
  a_ins_not_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> !sts.is_free && !sts.full) else $error("bad insert");
endmodule
